// ----- rtl/pcgb_pkg.sv -----
// ----------------------------------------------------------------------------
// pcgb_pkg: shared constants, types and functions
// Multiplier halves, register indexes, generator control bundle and the
// XSH-RR output permutation.
// ----------------------------------------------------------------------------
`default_nettype none

package pcgb_pkg;

	localparam int StateW = 64;
	localparam int WordW  = 32;
	localparam int CfgW   = 64;
	localparam int CfgIdxW = 2;

	// LCG multiplier 6364136223846793005, split into 32-bit halves
	localparam logic [WordW-1:0] MultLo = 32'h4C957F2D;
	localparam logic [WordW-1:0] MultHi = 32'h5851F42D;

	localparam logic [CfgIdxW-1:0] RegInitState = 2'd0;
	localparam logic [CfgIdxW-1:0] RegInitSeq   = 2'd1;

	// control bundle from the sequencer to the generator core
	typedef struct packed {
		logic clear;   // state = 0, increment from the sequence register
		logic add;     // state += init_state
		logic step;    // advance the LCG once
	} lcg_ctl_t;

	// XSH-RR: xorshift high bits, then rotate right by the top five bits
	function automatic logic [WordW-1:0] xsh_rr(input logic [StateW-1:0] old);
		logic [StateW-1:0] mix;
		logic [WordW-1:0]  xs;
		logic [4:0]        rot;
		logic [5:0]        lsh;
		mix = (old >> 18) ^ old;
		xs  = mix[58:27];
		rot = old[63:59];
		lsh = 6'd32 - {1'b0, rot};
		return (xs >> rot) | (xs << lsh);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/pcgb_lcg.sv -----
// ----------------------------------------------------------------------------
// pcgb_lcg: generator state and LCG step unit
// Holds state and increment; one step runs the 64-bit modular multiply as
// three 32x32 partial products through a single shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module pcgb_lcg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire pcgb_pkg::lcg_ctl_t          ctl,
	input  wire logic [pcgb_pkg::CfgW-1:0]   init_state,
	input  wire logic [pcgb_pkg::CfgW-1:0]   init_seq,
	output logic [pcgb_pkg::WordW-1:0]       draw,
	output logic                             busy
);
	import pcgb_pkg::*;

	logic [StateW-1:0] state_q;
	logic [StateW-1:0] inc_q;
	logic [StateW-1:0] acc_q;
	logic [StateW-1:0] prod_q;
	logic [1:0]        cnt_q;
	logic              busy_q;
	logic [WordW-1:0]  mul_a;
	logic [WordW-1:0]  mul_b;
	logic [StateW-1:0] mul_p;

	// partial products: lo*lo, lo*hi, hi*lo (hi*hi falls outside 2^64)
	assign mul_a = (cnt_q == 2'd2) ? state_q[63:32] : state_q[31:0];
	assign mul_b = (cnt_q == 2'd1) ? MultHi : MultLo;
	assign mul_p = mul_a * mul_b;

	assign draw = xsh_rr(state_q);
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else if (ctl.clear) begin
			busy_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == 2'd3) begin
				busy_q <= 1'b0;
			end
		end else if (ctl.step) begin
			busy_q <= 1'b1;
			cnt_q  <= 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			state_q <= '0;
			inc_q   <= {init_seq[62:0], 1'b1};
		end else if (busy_q) begin
			unique case (cnt_q)
				2'd1: begin
					acc_q  <= prod_q + inc_q;
					prod_q <= mul_p;
				end
				2'd2: begin
					acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
					prod_q       <= mul_p;
				end
				2'd3: begin
					state_q <= {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
				end
				default: begin
					prod_q <= mul_p;
				end
			endcase
		end else if (ctl.add) begin
			state_q <= state_q + init_state;
		end else if (ctl.step) begin
			prod_q <= mul_p;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pcgb_div.sv -----
// ----------------------------------------------------------------------------
// pcgb_div: serial remainder unit
// Restoring division, one quotient bit per cycle; returns the 32-bit
// remainder with a one-cycle done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module pcgb_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [pcgb_pkg::WordW-1:0]   dividend,
	input  wire logic [pcgb_pkg::WordW-1:0]   divisor,
	output logic                              done,
	output logic [pcgb_pkg::WordW-1:0]        remainder
);
	import pcgb_pkg::*;

	logic [WordW-1:0] dvd_q;
	logic [WordW-1:0] dvs_q;
	logic [WordW-1:0] rem_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [WordW:0]   trial;
	logic [WordW:0]   diff;
	logic             ge;

	assign trial = {rem_q, dvd_q[WordW-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	assign done      = done_q;
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= ge ? diff[WordW-1:0] : trial[WordW-1:0];
			dvd_q <= {dvd_q[WordW-2:0], 1'b0};
		end else if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pcg32_bounded_random.sv -----
// ----------------------------------------------------------------------------
// pcg32_bounded_random: PCG32 XSH-RR generator with bounded draws
// Sequencer around a shared LCG step unit and a serial remainder unit.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. A raw draw (kind 0) waits on
// the LCG step, which runs the 64-bit multiply as three 32x32 partial
// products on one multiplier. A bounded draw (kind 1) makes two passes
// through the bit-serial remainder unit (threshold, then final modulo); the
// first draw is generated while the threshold is being computed, and every
// rejected draw adds a further LCG step. A bounded draw with zero range
// returns minimum with range_error set and leaves the generator untouched.
// After reset, and after each write to init_state or init_sequence, the
// block re-seeds itself and holds in_stall meanwhile; writes to any other
// index are dropped. A finished result sits in the output register while
// the next transaction is accepted.
`default_nettype none

module pcg32_bounded_random (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [pcgb_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [pcgb_pkg::CfgW-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          kind,
	input  wire logic [pcgb_pkg::WordW-1:0]    minimum,
	input  wire logic [pcgb_pkg::WordW-1:0]    exclusive_bound,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [pcgb_pkg::WordW-1:0]         value,
	output logic                               range_error
);
	import pcgb_pkg::*;

	// sequencer states
	localparam logic [3:0] ST_RS_CLR   = 4'd0;
	localparam logic [3:0] ST_RS_STEP1 = 4'd1;
	localparam logic [3:0] ST_RS_WAIT1 = 4'd2;
	localparam logic [3:0] ST_RS_ADD   = 4'd3;
	localparam logic [3:0] ST_RS_STEP2 = 4'd4;
	localparam logic [3:0] ST_RS_WAIT2 = 4'd5;
	localparam logic [3:0] ST_IDLE     = 4'd6;
	localparam logic [3:0] ST_RAW_WAIT = 4'd7;
	localparam logic [3:0] ST_THR_WAIT = 4'd8;
	localparam logic [3:0] ST_CHECK    = 4'd9;
	localparam logic [3:0] ST_MOD_WAIT = 4'd10;
	localparam logic [3:0] ST_RESULT   = 4'd11;

	logic [3:0]       st_q;
	logic [CfgW-1:0]  init_state_q;
	logic [CfgW-1:0]  init_seq_q;
	logic [WordW-1:0] lo_q;
	logic [WordW-1:0] range_q;
	logic [WordW-1:0] thr_q;
	logic [WordW-1:0] draw_q;
	logic [WordW-1:0] res_val_q;
	logic             res_err_q;
	logic [WordW-1:0] out_val_q;
	logic             out_err_q;
	logic             out_valid_q;

	logic             cfg_hit;
	logic             in_acc;
	logic             out_free;
	logic [WordW-1:0] in_range;
	logic             draw_ok;
	lcg_ctl_t         lcg_ctl;
	logic [WordW-1:0] lcg_draw;
	logic             lcg_busy;
	logic             div_start;
	logic [WordW-1:0] div_dvd;
	logic [WordW-1:0] div_dvs;
	logic             div_done;
	logic [WordW-1:0] div_rem;

	// only listed registers trigger a re-seed
	assign cfg_hit  = cfg_we && (cfg_index == RegInitState || cfg_index == RegInitSeq);
	// hold off input during a config write so the two never share an edge
	assign in_stall = (st_q != ST_IDLE) || cfg_we;
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_range = exclusive_bound - minimum;
	assign draw_ok  = draw_q >= thr_q;

	assign out_valid   = out_valid_q;
	assign value       = out_val_q;
	assign range_error = out_err_q;

	pcgb_lcg u_lcg (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (lcg_ctl),
		.init_state (init_state_q),
		.init_seq   (init_seq_q),
		.draw       (lcg_draw),
		.busy       (lcg_busy)
	);

	pcgb_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.done      (div_done),
		.remainder (div_rem)
	);

	// drive the shared units from the sequencer state
	always_comb begin
		lcg_ctl   = '0;
		div_start = 1'b0;
		div_dvd   = draw_q;
		div_dvs   = range_q;
		unique case (st_q)
			ST_RS_CLR: begin
				lcg_ctl.clear = 1'b1;
			end
			ST_RS_STEP1, ST_RS_STEP2: begin
				lcg_ctl.step = 1'b1;
			end
			ST_RS_ADD: begin
				lcg_ctl.add = 1'b1;
			end
			ST_IDLE: begin
				// raw draw, or bounded draw with a nonzero range
				if (in_acc && (!kind || in_range != '0)) begin
					lcg_ctl.step = 1'b1;
				end
				// threshold = (2^32 - range) mod range, run alongside the first draw
				if (in_acc && kind && in_range != '0) begin
					div_start = 1'b1;
					div_dvd   = '0 - in_range;
					div_dvs   = in_range;
				end
			end
			ST_CHECK: begin
				if (!lcg_busy) begin
					if (draw_ok) begin
						div_start = 1'b1;
					end else begin
						lcg_ctl.step = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_state_q <= '0;
			init_seq_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegInitState: init_state_q <= cfg_data;
				RegInitSeq:   init_seq_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RS_CLR;
		end else if (cfg_hit) begin
			// restart seeding from scratch with the new register value
			st_q <= ST_RS_CLR;
		end else begin
			unique case (st_q)
				ST_RS_CLR:   st_q <= ST_RS_STEP1;
				ST_RS_STEP1: st_q <= ST_RS_WAIT1;
				ST_RS_WAIT1: if (!lcg_busy) st_q <= ST_RS_ADD;
				ST_RS_ADD:   st_q <= ST_RS_STEP2;
				ST_RS_STEP2: st_q <= ST_RS_WAIT2;
				ST_RS_WAIT2: if (!lcg_busy) st_q <= ST_IDLE;
				ST_IDLE: begin
					if (in_acc) begin
						if (!kind) begin
							st_q <= ST_RAW_WAIT;
						end else if (in_range == '0) begin
							st_q <= ST_RESULT;
						end else begin
							st_q <= ST_THR_WAIT;
						end
					end
				end
				ST_RAW_WAIT: if (!lcg_busy) st_q <= ST_RESULT;
				ST_THR_WAIT: if (div_done) st_q <= ST_CHECK;
				ST_CHECK:    if (!lcg_busy && draw_ok) st_q <= ST_MOD_WAIT;
				ST_MOD_WAIT: if (div_done) st_q <= ST_RESULT;
				ST_RESULT:   if (out_free) st_q <= ST_IDLE;
				default:     st_q <= ST_RS_CLR;
			endcase
		end
	end

	// working registers of the current transaction
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (in_acc) begin
					lo_q      <= minimum;
					range_q   <= in_range;
					// draw comes from the state before the step advances it
					draw_q    <= lcg_draw;
					res_val_q <= (kind) ? minimum : lcg_draw;
					res_err_q <= kind && (in_range == '0);
				end
			end
			ST_THR_WAIT: begin
				if (div_done) begin
					thr_q <= div_rem;
				end
			end
			ST_CHECK: begin
				// rejected: capture the next draw as its step is issued
				if (!lcg_busy && !draw_ok) begin
					draw_q <= lcg_draw;
				end
			end
			ST_MOD_WAIT: begin
				if (div_done) begin
					res_val_q <= div_rem + lo_q;
					res_err_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_q == ST_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_RESULT && out_free) begin
			out_val_q <= res_val_q;
			out_err_q <= res_err_q;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pcgb_chk.sv -----
// ----------------------------------------------------------------------------
// pcgb_chk: port-level checks for pcg32_bounded_random
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module pcgb_chk (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [pcgb_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire logic [pcgb_pkg::WordW-1:0]    value,
	input  wire logic                          range_error
);
	import pcgb_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value) && $stable(range_error))
		else $error("stalled result changed");

	// an accepted transaction makes the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after acceptance");

	// a write to a listed register starts a re-seed
	a_reseed_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == RegInitState || cfg_index == RegInitSeq) |=> in_stall)
		else $error("no re-seed after a config write");

	// a new result only appears at the end of a busy period
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work in progress");

endmodule

bind pcg32_bounded_random pcgb_chk u_pcgb_chk (.*);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for pcg32_bounded_random
// Drives raw and bounded draws through the valid/stall channels and predicts
// every result with a bit-true PCG32 XSH-RR model kept in step with the
// seed registers. Covers field extremes, zero and wrapped ranges, rejection-heavy
// ranges, ignored register indexes, long output back-pressure and random traffic.
// ----------------------------------------------------------------------------

module tb_top;

	import pcgb_pkg::*;

	localparam logic DrawRaw     = 1'b0;
	localparam logic DrawBounded = 1'b1;

	// indexes outside the register list; the block drops these writes
	localparam logic [CfgIdxW-1:0] RegSpareA = 2'd2;
	localparam logic [CfgIdxW-1:0] RegSpareB = 2'd3;

	localparam logic [63:0] LcgMult    = 64'h5851_F42D_4C95_7F2D;
	localparam int          DrainPause = 100;     // longer than a bounded draw
	localparam int          HoldCycles = 600;     // long receiver hold-off
	localparam int          CycleLimit = 1_000_000;
	localparam int          MaxPrints  = 40;

	typedef struct packed {
		logic [WordW-1:0] value;
		logic             range_error;
	} draw_result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgW-1:0]    cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic               kind;
	logic [WordW-1:0]   minimum;
	logic [WordW-1:0]   exclusive_bound;
	logic               out_valid;
	logic               out_stall;
	logic [WordW-1:0]   value;
	logic               range_error;

	// generator copy and seed registers as the block should hold them
	logic [63:0] lcg_state;
	logic [63:0] lcg_increment;
	logic [63:0] seed_offset;
	logic [63:0] seed_stream;

	draw_result_t expected_draws[$];
	int           mismatch_count;
	int           cycle_count;
	bit           src_gaps;
	bit           sink_gaps;
	bit           holdoff_req;

	pcg32_bounded_random u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.kind            (kind),
		.minimum         (minimum),
		.exclusive_bound (exclusive_bound),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.value           (value),
		.range_error     (range_error)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// XSH-RR permutation of the pre-advance state: rotating right is the same
	// as taking the low word of the doubled word shifted right
	function automatic logic [31:0] xsh_rr_of(input logic [63:0] old);
		logic [31:0] xs;
		logic [63:0] doubled;
		xs      = 32'(((old >> 18) ^ old) >> 27);
		doubled = {xs, xs} >> old[63:59];
		return doubled[31:0];
	endfunction

	// advance the copy once and return the word of the old state
	task automatic lcg_draw(output logic [31:0] word);
		word      = xsh_rr_of(lcg_state);
		lcg_state = lcg_state * LcgMult + lcg_increment;
	endtask

	// seeding: clear, pick the stream, step, add the offset, step again
	task automatic lcg_reseed();
		logic [31:0] discard;
		lcg_state     = 64'd0;
		lcg_increment = {seed_stream[62:0], 1'b1};
		lcg_draw(discard);
		lcg_state = lcg_state + seed_offset;
		lcg_draw(discard);
	endtask

	// work out the result of one accepted draw and queue it
	task automatic predict_draw(input logic k, input logic [31:0] lo, input logic [31:0] hi);
		draw_result_t res;
		logic [31:0]  span;
		logic [63:0]  threshold;
		logic [31:0]  word;
		res  = '0;
		span = hi - lo;
		if (k == DrawRaw) begin
			lcg_draw(word);
			res.value = word;
		end else if (span == 32'd0) begin
			// empty range: flag it, return the lower bound, leave the generator
			res.value       = lo;
			res.range_error = 1'b1;
		end else begin
			// reject words below 2^32 mod span so the remainder is unbiased
			threshold = (64'h1_0000_0000 - {32'd0, span}) % {32'd0, span};
			lcg_draw(word);
			while ({32'd0, word} < threshold)
				lcg_draw(word);
			res.value = (word % span) + lo;
		end
		expected_draws.push_back(res);
	endtask

	// ------------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < MaxPrints)
			$display("mismatch at cycle %0d: %s got %h expected %h",
				cycle_count, what, got, want);
		mismatch_count++;
	endtask

	// compare every transaction leaving the block with the oldest prediction
	always @(posedge clk) begin
		draw_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_draws.size() == 0) begin
				report_mismatch("result with nothing pending, value", value, '0);
			end else begin
				want = expected_draws.pop_front();
				if (value !== want.value)
					report_mismatch("value", value, want.value);
				if (range_error !== want.range_error)
					report_mismatch("range_error", 32'(range_error), 32'(want.range_error));
			end
		end
	end

	// end the run if it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: random stall bursts, plus one long hold-off on request
	// ------------------------------------------------------------------------
	initial begin
		int n;
		int burst;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (holdoff_req) begin
				// hold the output long enough for the block to back up into its input
				holdoff_req = 1'b0;
				out_stall <= 1'b1;
				for (n = 0; n < HoldCycles; n++)
					@(posedge clk);
			end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
				burst = $urandom_range(1, 19);
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
			end else begin
				burst = $urandom_range(1, 24);
				out_stall <= 1'b0;
				repeat (burst) @(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Shared sender and register tasks
	// ------------------------------------------------------------------------

	// offer one draw, hold it until accepted, then predict its result
	task automatic send_draw(input logic k, input logic [31:0] lo, input logic [31:0] hi);
		int gap;
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		kind            <= k;
		minimum         <= lo;
		exclusive_bound <= hi;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_draw(k, lo, hi);
	endtask

	// drop valid and wait until every predicted result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_draws.size() != 0)
			@(posedge clk);
		repeat (DrainPause) @(posedge clk);
	endtask

	// write one register while idle and mirror any re-seed it causes
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == RegInitState) begin
			seed_offset = data;
			lcg_reseed();
		end else if (idx == RegInitSeq) begin
			seed_stream = data;
			lcg_reseed();
		end
	endtask

	// one random draw: bounded shapes chosen to hit rejection, wrap and empty ranges
	task automatic send_random_draw();
		logic [31:0] lo;
		logic [31:0] hi;
		lo = $urandom;
		hi = $urandom;
		if ($urandom_range(0, 1) == 0) begin
			send_draw(DrawRaw, lo, hi);
		end else begin
			case ($urandom_range(0, 9))
				0: hi = lo;
				1: hi = lo + $urandom_range(1, 16);
				2: hi = lo + 32'h8000_0000 + $urandom_range(0, 8) - 32'd4;
				3: begin
					lo = lo | 32'h8000_0000;
					hi = hi & 32'h7FFF_FFFF;
				end
				4: hi = lo + ($urandom | 32'h8000_0000);
				default: ;
			endcase
			send_draw(DrawBounded, lo, hi);
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// field extremes and every special case, at the reset seeding
	task automatic test_directed_extremes();
		send_draw(DrawRaw, 32'h0000_0000, 32'h0000_0000);
		send_draw(DrawRaw, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_draw(DrawRaw, $urandom, $urandom);
		send_draw(DrawBounded, 32'h0000_0000, 32'hFFFF_FFFF);
		send_draw(DrawBounded, 32'h0000_0000, 32'h0000_0001);
		send_draw(DrawBounded, 32'h0000_0000, 32'h0000_0000);
		send_draw(DrawBounded, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_draw(DrawBounded, 32'h1234_5678, 32'h1234_5678);
		send_draw(DrawBounded, 32'hFFFF_FFF0, 32'h0000_0010);
		send_draw(DrawBounded, 32'hFFFF_FFFF, 32'h0000_0000);
		send_draw(DrawBounded, 32'h0000_0000, 32'h8000_0001);
		send_draw(DrawBounded, 32'h0000_0000, 32'h8000_0000);
		send_draw(DrawBounded, 32'h8000_0000, 32'h7FFF_FFFF);
		send_draw(DrawBounded, 32'h7FFF_FFFF, 32'h8000_0002);
		send_draw(DrawBounded, 32'h0000_0007, 32'h0000_000A);
		send_draw(DrawRaw, 32'h5555_5555, 32'hAAAA_AAAA);
	endtask

	// dropped indexes must not re-seed; real writes re-seed at extremes
	task automatic test_config_settings();
		int i;
		write_reg(RegSpareA, {$urandom, $urandom});
		write_reg(RegSpareB, {64{1'b1}});
		for (i = 0; i < 4; i++)
			send_random_draw();
		write_reg(RegInitState, {64{1'b1}});
		for (i = 0; i < 4; i++)
			send_random_draw();
		write_reg(RegInitSeq, {64{1'b1}});
		for (i = 0; i < 4; i++)
			send_random_draw();
		write_reg(RegInitState, 64'd0);
		write_reg(RegInitSeq, 64'd0);
		for (i = 0; i < 4; i++)
			send_random_draw();
	endtask

	// stall the output for a long stretch while the sender keeps offering
	task automatic test_long_holdoff();
		int i;
		wait_drained();
		holdoff_req = 1'b1;
		for (i = 0; i < 12; i++)
			send_draw(i[0] ? DrawBounded : DrawRaw, $urandom, $urandom);
	endtask

	// random traffic over several seed settings
	task automatic test_random_draws();
		int s;
		int i;
		logic [63:0] offsets[4];
		logic [63:0] streams[4];
		offsets = '{{64{1'b1}}, 64'd0, {$urandom, $urandom}, {64{1'b1}}};
		streams = '{{64{1'b1}}, {64{1'b1}}, {$urandom, $urandom}, 64'd0};
		for (s = 0; s < 4; s++) begin
			write_reg(RegInitState, offsets[s]);
			write_reg(RegInitSeq, streams[s]);
			for (i = 0; i < 350; i++)
				send_random_draw();
		end
	endtask

	// back-to-back traffic with both sides always ready
	task automatic test_no_idle();
		int i;
		wait_drained();
		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		write_reg(RegInitState, {$urandom, $urandom});
		for (i = 0; i < 150; i++)
			send_random_draw();
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		// every input known from time zero; reset held, then released
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = RegInitState;
		cfg_data        = '0;
		in_valid        = 1'b0;
		kind            = DrawRaw;
		minimum         = '0;
		exclusive_bound = '0;
		out_stall       = 1'b0;
		mismatch_count  = 0;
		cycle_count     = 0;
		src_gaps        = 1'b1;
		sink_gaps       = 1'b1;
		holdoff_req     = 1'b0;
		seed_offset     = 64'd0;
		seed_stream     = 64'd0;
		lcg_reseed();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_config_settings();
		test_long_holdoff();
		test_random_draws();
		test_no_idle();

		wait_drained();
		if (mismatch_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
